### rtl/lcdw_pkg.sv
// lcdw_pkg: command codes, parameter byte positions and the pixel result type
// shared by the LCD window writer modules. No dependencies.
package lcdw_pkg;

   localparam logic [7:0] CMD_NONE         = 8'h00;
   localparam logic [7:0] CMD_SOFT_RESET   = 8'h01;
   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   // position of a parameter byte after column-set / page-set
   localparam logic [2:0] PARAM_START_HI = 3'd0;
   localparam logic [2:0] PARAM_START_LO = 3'd1;
   localparam logic [2:0] PARAM_END_HI   = 3'd2;
   localparam logic [2:0] PARAM_END_LO   = 3'd3;
   localparam logic [2:0] PARAM_DONE     = 3'd4;

   typedef struct packed {
      logic        hit;
      logic [15:0] color;
      logic [8:0]  y;
      logic [7:0]  x;
   } pixel_type;

endpackage

### rtl/lcdw_window.sv
// lcdw_window: command decode, address window registers and write pointer.
// Produces the pixel for an accepted data transaction. Depends on lcdw_pkg.
module lcdw_window import lcdw_pkg::*; #(
   parameter int PANEL_WIDTH  = 240,
   parameter int PANEL_HEIGHT = 320
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        action,
   input  logic [15:0] bus_value,
   output pixel_type   pixel
);

   localparam logic [15:0] COL_END_RST  = 16'(PANEL_WIDTH - 1);
   localparam logic [15:0] PAGE_END_RST = 16'(PANEL_HEIGHT - 1);
   localparam logic [15:0] WIDTH_LIM    = 16'(PANEL_WIDTH);
   localparam logic [15:0] HEIGHT_LIM   = 16'(PANEL_HEIGHT);

   logic [7:0]  active_command_ff, active_command_in;
   logic [2:0]  param_index_ff, param_index_in;
   logic [7:0]  held_high_ff, held_high_in;
   logic [15:0] column_start_ff, column_start_in;
   logic [15:0] column_end_ff, column_end_in;
   logic [15:0] page_start_ff, page_start_in;
   logic [15:0] page_end_ff, page_end_in;
   logic [15:0] write_column_ff, write_column_in;
   logic [15:0] write_page_ff, write_page_in;

   logic [7:0]  byte_val;
   logic [15:0] word_val;
   logic        is_column;
   logic        on_panel;

   assign byte_val  = bus_value[7:0];
   assign word_val  = {held_high_ff, byte_val};
   assign is_column = (active_command_ff == CMD_COLUMN_SET);
   assign on_panel  = (write_column_ff < WIDTH_LIM) && (write_page_ff < HEIGHT_LIM);

   always_comb begin
      active_command_in = active_command_ff;
      param_index_in    = param_index_ff;
      held_high_in      = held_high_ff;
      column_start_in   = column_start_ff;
      column_end_in     = column_end_ff;
      page_start_in     = page_start_ff;
      page_end_in       = page_end_ff;
      write_column_in   = write_column_ff;
      write_page_in     = write_page_ff;

      pixel.hit   = 1'b0;
      pixel.x     = write_column_ff[7:0];
      pixel.y     = write_page_ff[8:0];
      pixel.color = bus_value;

      if (accept && !action) begin
         if (byte_val == CMD_SOFT_RESET) begin
            active_command_in = CMD_NONE;
            param_index_in    = PARAM_START_HI;
            held_high_in      = 8'd0;
            column_start_in   = 16'd0;
            column_end_in     = COL_END_RST;
            page_start_in     = 16'd0;
            page_end_in       = PAGE_END_RST;
            write_column_in   = 16'd0;
            write_page_in     = 16'd0;
         end else begin
            active_command_in = byte_val;
            param_index_in    = PARAM_START_HI;
            if (byte_val == CMD_MEMORY_WRITE) begin
               write_column_in = column_start_ff;
               write_page_in   = page_start_ff;
            end
         end
      end else if (accept && action) begin
         if (is_column || active_command_ff == CMD_PAGE_SET) begin
            if (param_index_ff != PARAM_DONE) begin
               param_index_in = param_index_ff + 3'd1;
            end
            case (param_index_ff)
               PARAM_START_HI, PARAM_END_HI: begin
                  held_high_in = byte_val;
               end
               PARAM_START_LO: begin
                  if (is_column) column_start_in = word_val;
                  else page_start_in = word_val;
               end
               PARAM_END_LO: begin
                  if (is_column) column_end_in = word_val;
                  else page_end_in = word_val;
               end
               default: begin
                  param_index_in = param_index_ff;
               end
            endcase
         end else if (active_command_ff == CMD_MEMORY_WRITE) begin
            pixel.hit = on_panel;
            // raster advance: column to window end, then wrap and step the page
            if (write_column_ff >= column_end_ff) begin
               write_column_in = column_start_ff;
               if (write_page_ff >= page_end_ff) write_page_in = page_start_ff;
               else write_page_in = write_page_ff + 16'd1;
            end else begin
               write_column_in = write_column_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_command_ff <= CMD_NONE;
         param_index_ff    <= PARAM_START_HI;
         held_high_ff      <= 8'd0;
         column_start_ff   <= 16'd0;
         column_end_ff     <= COL_END_RST;
         page_start_ff     <= 16'd0;
         page_end_ff       <= PAGE_END_RST;
         write_column_ff   <= 16'd0;
         write_page_ff     <= 16'd0;
      end else begin
         active_command_ff <= active_command_in;
         param_index_ff    <= param_index_in;
         held_high_ff      <= held_high_in;
         column_start_ff   <= column_start_in;
         column_end_ff     <= column_end_in;
         page_start_ff     <= page_start_in;
         page_end_ff       <= page_end_in;
         write_column_ff   <= write_column_in;
         write_page_ff     <= write_page_in;
      end
   end

endmodule

### rtl/lcd_gram_window_writer.sv
// lcd_gram_window_writer: panel-side LCD controller address window and
// memory-write path. An on-panel memory-write pixel shows on rsp in the cycle
// after acceptance. Throughput: one bus transaction per cycle unless rsp stalls,
// set by the single pass through the window/pointer update and the rsp output register.
// Reset (synchronous, active high) restores the full-panel window, clears the
// active command and the write pointer, and empties the output register.
// Depends on lcdw_pkg and lcdw_window.
module lcd_gram_window_writer import lcdw_pkg::*; #(
   parameter int PANEL_WIDTH  = 240,
   parameter int PANEL_HEIGHT = 320
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // bus_value[15:0]
   input  logic        req_tuser,   // action: 0 command, 1 data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // pixel_x[7:0], pixel_y[16:8], pixel_color[32:17], zero
);

   logic      req_accept;
   pixel_type pixel;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   // take a new transaction whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   lcdw_window #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .action    (req_tuser),
      .bus_value (req_tdata),
      .pixel     (pixel)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (pixel.hit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, pixel.color, pixel.y, pixel.x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a command transaction never creates a pixel
   a_cmd_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tuser && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("pixel after command transaction");

   // reported pixels lie on the panel
   a_x_on_panel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[7:0]) < 32'(PANEL_WIDTH)))
      else $error("pixel column off panel");

   a_y_on_panel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[16:8]) < 32'(PANEL_HEIGHT)))
      else $error("pixel row off panel");

endmodule
